// ===== rtl/tdq_pkg.sv =====
`default_nettype none

package tdq_pkg;

    localparam int LAT_W   = 8;
    localparam int ROUTE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = LAT_W;

    localparam logic [LAT_W-1:0] LAT_UPPER_RESET     = 8'd15;
    localparam logic [LAT_W-1:0] LAT_TO_MEM_RESET    = 8'd5;
    localparam logic [LAT_W-1:0] LAT_FROM_MEM_RESET  = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAT_UPPER    = 2'd0,
        CFG_LAT_TO_MEM   = 2'd1,
        CFG_LAT_FROM_MEM = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_UPPER    = 2'd0,
        ROUTE_TO_MEM   = 2'd1,
        ROUTE_FROM_MEM = 2'd2
    } route_t;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_REJECT  = 1'b1
    } kind_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               load;
        logic               tick;
        logic               pop;
        logic [LAT_W-1:0]   countdown;
        logic [ROUTE_W-1:0] route;
    } cell_ctrl_t;

    // ripples along the row, oldest cell first
    typedef struct packed {
        logic any_due;
        logic multi_due;
        logic any_zero;
    } scan_t;

endpackage

`default_nettype wire

// ===== rtl/tdq_in_if.sv =====
`default_nettype none

interface tdq_in_if #(
    parameter int HANDLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [1:0]             direction;
    logic [HANDLE_BITS-1:0] block_ref;

    modport source (output valid, output operation, output direction, output block_ref,
                    input ready);
    modport sink   (input valid, input operation, input direction, input block_ref,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tdq_out_if.sv =====
`default_nettype none

interface tdq_out_if #(
    parameter int HANDLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [1:0]             route;
    logic [HANDLE_BITS-1:0] block_handle;
    logic                   last;

    modport source (output valid, output kind, output route, output block_handle,
                    output last, input ready);
    modport sink   (input valid, input kind, input route, input block_handle,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/timed_message_delay_queue.sv =====
// channel  | role   | payload
// ---------+--------+-----------------------------------------------
// in_ch    | sink   | operation, direction, block_ref
// out_ch   | source | kind, route, block_handle, last
// cfg      | write  | cfg_we, cfg_index, cfg_data (three latencies)
//
// an enqueue loads the first free cell; a tick ages the row of cells, and if
// any entry was already at zero the due entries are then popped in turn,
// oldest first, while the row shifts down behind each
// a rejected enqueue (queue full) puts its flag item in the output register
// rst_n clears the cells' valid state, the controller and the output valid at once
// a stalled output holds its item; input is taken only in idle when the register frees
`default_nettype none

module timed_message_delay_queue
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tdq_in_if.sink                     in_ch,
    tdq_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [LAT_W-1:0] lat_upper_reg, lat_to_mem_reg, lat_from_mem_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [ROUTE_W-1:0]     out_route_reg, out_route_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic                   out_last_reg, out_last_next;

    cell_ctrl_t ctrl;
    logic       out_free;
    logic       accept;
    logic       route_ok;
    logic [LAT_W-1:0] lat_sel;

    logic                   c_valid     [QUEUE_DEPTH+1];
    logic [LAT_W-1:0]       c_countdown [QUEUE_DEPTH+1];
    logic [ROUTE_W-1:0]     c_route     [QUEUE_DEPTH+1];
    logic                   c_due       [QUEUE_DEPTH+1];
    logic [HANDLE_BITS-1:0] c_handle    [QUEUE_DEPTH+1];
    scan_t                  c_scan      [QUEUE_DEPTH+1];
    logic [ROUTE_W-1:0]     c_sel_route [QUEUE_DEPTH+1];
    logic [HANDLE_BITS-1:0] c_sel_handle[QUEUE_DEPTH+1];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_upper_reg    <= LAT_UPPER_RESET;
            lat_to_mem_reg   <= LAT_TO_MEM_RESET;
            lat_from_mem_reg <= LAT_FROM_MEM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LAT_UPPER:    lat_upper_reg    <= cfg_data;
                CFG_LAT_TO_MEM:   lat_to_mem_reg   <= cfg_data;
                CFG_LAT_FROM_MEM: lat_from_mem_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        route_ok = 1'b1;
        case (route_t'(in_ch.direction))
            ROUTE_UPPER:    lat_sel = lat_upper_reg;
            ROUTE_TO_MEM:   lat_sel = lat_to_mem_reg;
            ROUTE_FROM_MEM: lat_sel = lat_from_mem_reg;
            default:
            begin
                lat_sel  = '0;
                route_ok = 1'b0;
            end
        endcase
    end

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign accept      = in_ch.valid && in_ch.ready;

    // row of cells, cell 0 holds the oldest entry
    assign c_valid[QUEUE_DEPTH]      = 1'b0;
    assign c_countdown[QUEUE_DEPTH]  = '0;
    assign c_route[QUEUE_DEPTH]      = '0;
    assign c_due[QUEUE_DEPTH]        = 1'b0;
    assign c_handle[QUEUE_DEPTH]     = '0;
    assign c_scan[0]                 = '0;
    assign c_sel_route[0]            = '0;
    assign c_sel_handle[0]           = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic prev_valid;
        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = c_valid[i-1];
        end

        tdq_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .load_handle    (in_ch.block_ref),
            .prev_valid     (prev_valid),
            .nxt_valid      (c_valid[i+1]),
            .nxt_countdown  (c_countdown[i+1]),
            .nxt_route      (c_route[i+1]),
            .nxt_due        (c_due[i+1]),
            .nxt_handle     (c_handle[i+1]),
            .scan_in        (c_scan[i]),
            .sel_route_in   (c_sel_route[i]),
            .sel_handle_in  (c_sel_handle[i]),
            .valid          (c_valid[i]),
            .countdown      (c_countdown[i]),
            .route          (c_route[i]),
            .due            (c_due[i]),
            .handle         (c_handle[i]),
            .scan_out       (c_scan[i+1]),
            .sel_route_out  (c_sel_route[i+1]),
            .sel_handle_out (c_sel_handle[i+1])
        );
    end

    // controller
    always_comb
    begin
        state_next      = state_reg;
        ctrl.load       = 1'b0;
        ctrl.tick       = 1'b0;
        ctrl.pop        = 1'b0;
        ctrl.countdown  = (lat_sel == '0) ? '0 : lat_sel - LAT_W'(1);
        ctrl.route      = in_ch.direction;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_kind_next   = out_kind_reg;
        out_route_next  = out_route_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(in_ch.operation) == OP_TICK)
                    begin
                        ctrl.tick = 1'b1;
                        if (c_scan[QUEUE_DEPTH].any_zero)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else if (route_ok)
                    begin
                        if (c_valid[QUEUE_DEPTH-1])
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_REJECT;
                            out_route_next  = in_ch.direction;
                            out_handle_next = in_ch.block_ref;
                            out_last_next   = 1'b1;
                        end
                        else
                        begin
                            ctrl.load = 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    ctrl.pop        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DELIVER;
                    out_route_next  = c_sel_route[QUEUE_DEPTH];
                    out_handle_next = c_sel_handle[QUEUE_DEPTH];
                    out_last_next   = !c_scan[QUEUE_DEPTH].multi_due;
                    if (!c_scan[QUEUE_DEPTH].multi_due)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_route_reg  <= out_route_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.route        = out_route_reg;
    assign out_ch.block_handle = out_handle_reg;
    assign out_ch.last         = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/tdq_cell.sv =====
`default_nettype none

module tdq_cell
    import tdq_pkg::*;
#(
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_ctrl_t             ctrl,
    input  wire logic [HANDLE_BITS-1:0] load_handle,
    input  wire logic                   prev_valid,
    input  wire logic                   nxt_valid,
    input  wire logic [LAT_W-1:0]       nxt_countdown,
    input  wire logic [ROUTE_W-1:0]     nxt_route,
    input  wire logic                   nxt_due,
    input  wire logic [HANDLE_BITS-1:0] nxt_handle,
    input  wire scan_t                  scan_in,
    input  wire logic [ROUTE_W-1:0]     sel_route_in,
    input  wire logic [HANDLE_BITS-1:0] sel_handle_in,
    output logic                        valid,
    output logic [LAT_W-1:0]            countdown,
    output logic [ROUTE_W-1:0]          route,
    output logic                        due,
    output logic [HANDLE_BITS-1:0]      handle,
    output scan_t                       scan_out,
    output logic [ROUTE_W-1:0]          sel_route_out,
    output logic [HANDLE_BITS-1:0]      sel_handle_out
);

    logic                   valid_reg, valid_next;
    logic [LAT_W-1:0]       countdown_reg, countdown_next;
    logic                   due_reg, due_next;
    logic [ROUTE_W-1:0]     route_reg, route_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic                   first_due;
    logic                   shift;

    assign first_due = due_reg && !scan_in.any_due;
    assign shift     = ctrl.pop && (due_reg || scan_in.any_due);

    assign scan_out.any_due   = scan_in.any_due || due_reg;
    assign scan_out.multi_due = scan_in.multi_due || (scan_in.any_due && due_reg);
    assign scan_out.any_zero  = scan_in.any_zero || (valid_reg && (countdown_reg == '0));

    assign sel_route_out  = sel_route_in | (first_due ? route_reg : '0);
    assign sel_handle_out = sel_handle_in | (first_due ? handle_reg : '0);

    always_comb
    begin
        valid_next     = valid_reg;
        countdown_next = countdown_reg;
        due_next       = due_reg;
        route_next     = route_reg;
        handle_next    = handle_reg;
        if (ctrl.load && !valid_reg && prev_valid)
        begin
            valid_next     = 1'b1;
            countdown_next = ctrl.countdown;
            due_next       = 1'b0;
            route_next     = ctrl.route;
            handle_next    = load_handle;
        end
        else if (ctrl.tick && valid_reg)
        begin
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - LAT_W'(1);
            end
            else
            begin
                due_next = 1'b1;
            end
        end
        else if (shift)
        begin
            valid_next     = nxt_valid;
            countdown_next = nxt_countdown;
            due_next       = nxt_due;
            route_next     = nxt_route;
            handle_next    = nxt_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            countdown_reg <= '0;
            due_reg       <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            countdown_reg <= countdown_next;
            due_reg       <= due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        route_reg  <= route_next;
        handle_reg <= handle_next;
    end

    assign valid     = valid_reg;
    assign countdown = countdown_reg;
    assign route     = route_reg;
    assign due       = due_reg;
    assign handle    = handle_reg;

endmodule

`default_nettype wire
